>>> rtl/core/htmb_pkg.sv
`timescale 1ns / 1ps

package htmb_pkg;

    localparam int MAX_LEAVES = 256;
    localparam int IDX_W      = $clog2(MAX_LEAVES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ID_W       = 9;
    localparam int WT_W       = 32;
    localparam int LEAF_W     = 24;
    localparam int SYM_W      = 8;
    localparam int ACT_W      = 2;
    localparam int ST_W       = 3;
    localparam int ENTRY_W    = ID_W + WT_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_MERGE = 2'd2
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_CLEARED = 3'd0,
        ST_LOADED  = 3'd1,
        ST_MERGED  = 3'd2,
        ST_ROOT    = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_FULL    = 3'd5,
        ST_REFUSED = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_CLEAR,
        OP_LOAD,
        OP_REFUSE,
        OP_FULL,
        OP_EMPTY,
        OP_SCAN1,
        OP_SCAN2,
        OP_PACK,
        OP_APPEND,
        OP_ROOT,
        OP_PUBLISH
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN1,
        S_INIT2,
        S_SCAN2,
        S_INIT3,
        S_PACK,
        S_APPEND,
        S_ROOT_RD,
        S_ROOT,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   capture;
    } dp_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             merging;
        logic             cnt_zero;
        logic             cnt_one;
        logic             cnt_full;
        logic             scan_done;
        logic             out_free;
    } dp_stat_t;

endpackage

>>> rtl/core/huffman_tree_merge_builder_unit.sv
`timescale 1ns / 1ps

// Huffman tree builder. Each input beat carries an action (clear, load a leaf,
// or one merge step) with a symbol and a 24-bit weight; each beat except the
// unused action code gives exactly one result beat on the output channel.
// Both channels use valid/ready. One input beat is worked on at a time.
// A merge step runs two minimum scans and one packing pass over the list
// memory, each through its single registered read port. A root report (one
// entry left) reads that last entry back through the same port.
// The result sits in an output register; the next input beat is accepted and
// worked on while it waits. If the receiver stalls, the finished result of
// that next beat waits internally and in_ready stays low until it moves on.
// Reset empties the list, restarts node ids at zero and drops any pending
// result; the list memory itself is not cleared, since only entries below
// the live count are ever read.
module huffman_tree_merge_builder_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [htmb_pkg::ACT_W-1:0]   action,
    input  logic [htmb_pkg::SYM_W-1:0]   symbol,
    input  logic [htmb_pkg::LEAF_W-1:0]  weight,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [htmb_pkg::ST_W-1:0]    status,
    output logic [htmb_pkg::ID_W-1:0]    left_node,
    output logic [htmb_pkg::ID_W-1:0]    right_node,
    output logic [htmb_pkg::ID_W-1:0]    new_node,
    output logic [htmb_pkg::WT_W-1:0]    node_weight,
    output logic [htmb_pkg::SYM_W-1:0]   echo_symbol
);
    import htmb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    htmb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    htmb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .symbol      (symbol),
        .weight      (weight),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .left_node   (left_node),
        .right_node  (right_node),
        .new_node    (new_node),
        .node_weight (node_weight),
        .echo_symbol (echo_symbol)
    );

endmodule

>>> rtl/core/htmb_ctrl.sv
`timescale 1ns / 1ps

module htmb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  htmb_pkg::dp_stat_t stat,
    output htmb_pkg::dp_cmd_t  cmd
);
    import htmb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                unique case (stat.action)
                    ACT_CLEAR: state_next = S_DONE;
                    ACT_LOAD:  state_next = S_DONE;
                    ACT_MERGE:
                    begin
                        priority if (stat.cnt_zero)
                        begin
                            state_next = S_DONE;
                        end
                        else if (stat.cnt_one)
                        begin
                            state_next = S_ROOT_RD;
                        end
                        else
                        begin
                            state_next = S_SCAN1;
                        end
                    end
                    default:   state_next = S_IDLE;
                endcase
            end
            S_SCAN1:   if (stat.scan_done) state_next = S_INIT2;
            S_INIT2:   state_next = S_SCAN2;
            S_SCAN2:   if (stat.scan_done) state_next = S_INIT3;
            S_INIT3:   state_next = S_PACK;
            S_PACK:    if (stat.scan_done) state_next = S_APPEND;
            S_APPEND:  state_next = S_DONE;
            S_ROOT_RD: state_next = S_ROOT;
            S_ROOT:    state_next = S_DONE;
            S_DONE:    if (stat.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.op      = OP_NONE;
        cmd.capture = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DECIDE:
            begin
                unique case (stat.action)
                    ACT_CLEAR: cmd.op = OP_CLEAR;
                    ACT_LOAD:
                    begin
                        priority if (stat.merging)
                        begin
                            cmd.op = OP_REFUSE;
                        end
                        else if (stat.cnt_full)
                        begin
                            cmd.op = OP_FULL;
                        end
                        else
                        begin
                            cmd.op = OP_LOAD;
                        end
                    end
                    ACT_MERGE:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.op = OP_EMPTY;
                        end
                    end
                    default:   cmd.op = OP_NONE;
                endcase
            end
            S_SCAN1:   cmd.op = OP_SCAN1;
            S_INIT2:   cmd.op = OP_INIT;
            S_SCAN2:   cmd.op = OP_SCAN2;
            S_INIT3:   cmd.op = OP_INIT;
            S_PACK:    cmd.op = OP_PACK;
            S_APPEND:  cmd.op = OP_APPEND;
            S_ROOT_RD: cmd.op = OP_NONE;
            S_ROOT:    cmd.op = OP_ROOT;
            S_DONE:    cmd.op = stat.out_free ? OP_PUBLISH : OP_NONE;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> rtl/core/htmb_dp.sv
`timescale 1ns / 1ps

module htmb_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  htmb_pkg::dp_cmd_t            cmd,
    output htmb_pkg::dp_stat_t           stat,
    input  logic [htmb_pkg::ACT_W-1:0]   action,
    input  logic [htmb_pkg::SYM_W-1:0]   symbol,
    input  logic [htmb_pkg::LEAF_W-1:0]  weight,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [htmb_pkg::ST_W-1:0]    status,
    output logic [htmb_pkg::ID_W-1:0]    left_node,
    output logic [htmb_pkg::ID_W-1:0]    right_node,
    output logic [htmb_pkg::ID_W-1:0]    new_node,
    output logic [htmb_pkg::WT_W-1:0]    node_weight,
    output logic [htmb_pkg::SYM_W-1:0]   echo_symbol
);
    import htmb_pkg::*;

    // List storage: each entry holds {node id, weight}.
    logic [ENTRY_W-1:0] mem [MAX_LEAVES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [ENTRY_W-1:0] mem_wd;

    logic [ACT_W-1:0]  act_reg,  act_next;
    logic [SYM_W-1:0]  sym_reg,  sym_next;
    logic [LEAF_W-1:0] wt_reg,   wt_next;

    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic              merging_reg, merging_next;

    logic [CNT_W-1:0]  ptr_reg,    ptr_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic              found_reg,  found_next;

    logic [IDX_W-1:0]  sel1_idx_reg, sel1_idx_next;
    logic [ID_W-1:0]   sel1_id_reg,  sel1_id_next;
    logic [WT_W-1:0]   sel1_wt_reg,  sel1_wt_next;
    logic [IDX_W-1:0]  sel2_idx_reg, sel2_idx_next;
    logic [ID_W-1:0]   sel2_id_reg,  sel2_id_next;
    logic [WT_W-1:0]   sel2_wt_reg,  sel2_wt_next;

    status_t           res_st_reg,    res_st_next;
    logic [ID_W-1:0]   res_left_reg,  res_left_next;
    logic [ID_W-1:0]   res_right_reg, res_right_next;
    logic [ID_W-1:0]   res_new_reg,   res_new_next;
    logic [WT_W-1:0]   res_wt_reg,    res_wt_next;
    logic [SYM_W-1:0]  res_sym_reg,   res_sym_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_st_reg,    out_st_next;
    logic [ID_W-1:0]   out_left_reg,  out_left_next;
    logic [ID_W-1:0]   out_right_reg, out_right_next;
    logic [ID_W-1:0]   out_new_reg,   out_new_next;
    logic [WT_W-1:0]   out_wt_reg,    out_wt_next;
    logic [SYM_W-1:0]  out_sym_reg,   out_sym_next;

    logic [ID_W-1:0]   rd_id;
    logic [WT_W-1:0]   rd_wt;
    logic              scanning;
    logic              rd_issue;
    logic [WT_W-1:0]   best_wt;
    logic              better;
    logic              keep;
    logic [WT_W-1:0]   sum_wt;

    assign rd_id    = rd_data_reg[ENTRY_W-1:WT_W];
    assign rd_wt    = rd_data_reg[WT_W-1:0];
    assign scanning = (cmd.op == OP_SCAN1) || (cmd.op == OP_SCAN2) || (cmd.op == OP_PACK);
    assign rd_issue = scanning && (ptr_reg < count_reg);
    assign best_wt  = (cmd.op == OP_SCAN1) ? sel1_wt_reg : sel2_wt_reg;
    assign better   = !found_reg || (rd_wt < best_wt);
    // During the pack pass every entry except the two chosen minima slides down.
    assign keep     = rd_vld_reg && (rd_idx_reg != sel1_idx_reg) && (rd_idx_reg != sel2_idx_reg);
    assign sum_wt   = sel1_wt_reg + sel2_wt_reg;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = wr_ptr_reg;
        mem_wd = {next_id_reg, sum_wt};
        unique case (cmd.op)
            OP_LOAD:
            begin
                mem_we = 1'b1;
                mem_wa = count_reg[IDX_W-1:0];
                mem_wd = {next_id_reg, {(WT_W-LEAF_W){1'b0}}, wt_reg};
            end
            OP_PACK:
            begin
                mem_we = keep;
                mem_wd = rd_data_reg;
            end
            OP_APPEND:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        act_next       = act_reg;
        sym_next       = sym_reg;
        wt_next        = wt_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        merging_next   = merging_reg;
        ptr_next       = ptr_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = ptr_reg[IDX_W-1:0];
        wr_ptr_next    = wr_ptr_reg;
        found_next     = found_reg;
        sel1_idx_next  = sel1_idx_reg;
        sel1_id_next   = sel1_id_reg;
        sel1_wt_next   = sel1_wt_reg;
        sel2_idx_next  = sel2_idx_reg;
        sel2_id_next   = sel2_id_reg;
        sel2_wt_next   = sel2_wt_reg;
        res_st_next    = res_st_reg;
        res_left_next  = res_left_reg;
        res_right_next = res_right_reg;
        res_new_next   = res_new_reg;
        res_wt_next    = res_wt_reg;
        res_sym_next   = res_sym_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_st_next    = out_st_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_new_next   = out_new_reg;
        out_wt_next    = out_wt_reg;
        out_sym_next   = out_sym_reg;

        if (cmd.capture)
        begin
            act_next    = action;
            sym_next    = symbol;
            wt_next     = weight;
            ptr_next    = '0;
            wr_ptr_next = '0;
            found_next  = 1'b0;
        end

        if (rd_issue)
        begin
            ptr_next    = ptr_reg + CNT_W'(1);
            rd_vld_next = 1'b1;
        end

        unique case (cmd.op)
            OP_NONE:
            begin
                ptr_next = ptr_next;
            end
            OP_INIT:
            begin
                ptr_next    = '0;
                wr_ptr_next = '0;
                found_next  = 1'b0;
            end
            OP_CLEAR:
            begin
                count_next     = '0;
                next_id_next   = '0;
                merging_next   = 1'b0;
                res_st_next    = ST_CLEARED;
                res_left_next  = '0;
                res_right_next = '0;
                res_new_next   = '0;
                res_wt_next    = '0;
                res_sym_next   = '0;
            end
            OP_LOAD:
            begin
                count_next     = count_reg + CNT_W'(1);
                next_id_next   = next_id_reg + ID_W'(1);
                res_st_next    = ST_LOADED;
                res_left_next  = next_id_reg;
                res_right_next = '0;
                res_new_next   = '0;
                res_wt_next    = {{(WT_W-LEAF_W){1'b0}}, wt_reg};
                res_sym_next   = sym_reg;
            end
            OP_REFUSE, OP_FULL, OP_EMPTY:
            begin
                priority if (cmd.op == OP_REFUSE)
                begin
                    res_st_next = ST_REFUSED;
                end
                else if (cmd.op == OP_FULL)
                begin
                    res_st_next = ST_FULL;
                end
                else
                begin
                    res_st_next = ST_EMPTY;
                end
                res_left_next  = '0;
                res_right_next = '0;
                res_new_next   = '0;
                res_wt_next    = '0;
                res_sym_next   = '0;
            end
            OP_SCAN1:
            begin
                if (rd_vld_reg && better)
                begin
                    found_next    = 1'b1;
                    sel1_idx_next = rd_idx_reg;
                    sel1_id_next  = rd_id;
                    sel1_wt_next  = rd_wt;
                end
            end
            OP_SCAN2:
            begin
                // The entry taken by the first pass is skipped.
                if (rd_vld_reg && (rd_idx_reg != sel1_idx_reg) && better)
                begin
                    found_next    = 1'b1;
                    sel2_idx_next = rd_idx_reg;
                    sel2_id_next  = rd_id;
                    sel2_wt_next  = rd_wt;
                end
            end
            OP_PACK:
            begin
                if (keep)
                begin
                    wr_ptr_next = wr_ptr_reg + IDX_W'(1);
                end
            end
            OP_APPEND:
            begin
                count_next     = count_reg - CNT_W'(1);
                next_id_next   = next_id_reg + ID_W'(1);
                merging_next   = 1'b1;
                res_st_next    = ST_MERGED;
                res_left_next  = sel1_id_reg;
                res_right_next = sel2_id_reg;
                res_new_next   = next_id_reg;
                res_wt_next    = sum_wt;
                res_sym_next   = '0;
            end
            OP_ROOT:
            begin
                merging_next   = 1'b1;
                res_st_next    = ST_ROOT;
                res_left_next  = rd_id;
                res_right_next = '0;
                res_new_next   = '0;
                res_wt_next    = rd_wt;
                res_sym_next   = '0;
            end
            OP_PUBLISH:
            begin
                out_valid_next = 1'b1;
                out_st_next    = res_st_reg;
                out_left_next  = res_left_reg;
                out_right_next = res_right_reg;
                out_new_next   = res_new_reg;
                out_wt_next    = res_wt_reg;
                out_sym_next   = res_sym_reg;
            end
            default:
            begin
                ptr_next = ptr_next;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            next_id_reg   <= '0;
            merging_reg   <= 1'b0;
            ptr_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            wr_ptr_reg    <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            merging_reg   <= merging_next;
            ptr_reg       <= ptr_next;
            rd_vld_reg    <= rd_vld_next;
            wr_ptr_reg    <= wr_ptr_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        sym_reg       <= sym_next;
        wt_reg        <= wt_next;
        rd_idx_reg    <= rd_idx_next;
        sel1_idx_reg  <= sel1_idx_next;
        sel1_id_reg   <= sel1_id_next;
        sel1_wt_reg   <= sel1_wt_next;
        sel2_idx_reg  <= sel2_idx_next;
        sel2_id_reg   <= sel2_id_next;
        sel2_wt_reg   <= sel2_wt_next;
        res_st_reg    <= res_st_next;
        res_left_reg  <= res_left_next;
        res_right_reg <= res_right_next;
        res_new_reg   <= res_new_next;
        res_wt_reg    <= res_wt_next;
        res_sym_reg   <= res_sym_next;
        out_st_reg    <= out_st_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_new_reg   <= out_new_next;
        out_wt_reg    <= out_wt_next;
        out_sym_reg   <= out_sym_next;
    end

    assign stat.action    = act_reg;
    assign stat.merging   = merging_reg;
    assign stat.cnt_zero  = (count_reg == '0);
    assign stat.cnt_one   = (count_reg == CNT_W'(1));
    assign stat.cnt_full  = (count_reg >= CNT_W'(MAX_LEAVES));
    assign stat.scan_done = (ptr_reg >= count_reg) && !rd_vld_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign status      = out_st_reg;
    assign left_node   = out_left_reg;
    assign right_node  = out_right_reg;
    assign new_node    = out_new_reg;
    assign node_weight = out_wt_reg;
    assign echo_symbol = out_sym_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEAVES))
        else $error("list count above capacity");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUBLISH) |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a beat not yet taken");

    a_pack_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PACK && rd_vld_reg) |-> (wr_ptr_reg <= rd_idx_reg))
        else $error("pack write ran ahead of pack read");

    a_distinct_min: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_APPEND) |-> (sel1_idx_reg != sel2_idx_reg))
        else $error("both minima picked the same entry");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_APPEND) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("merge did not shrink the list by one");

endmodule

>>> bench/huffman_tree_merge_builder_unit_tb.sv
`timescale 1ns / 1ps

module huffman_tree_merge_builder_unit_tb;
    import htmb_pkg::*;

    // Action code 3 is not decoded; the block drops it without a result.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int TAIL_BEATS   = 40;
    localparam int DRAIN_CYCLES = 800;
    localparam int TOTAL_BEATS  = 650;

    typedef struct {
        logic [ACT_W-1:0]  action;
        logic [SYM_W-1:0]  symbol;
        logic [LEAF_W-1:0] weight;
        bit                drain_first;
    } tree_beat_t;

    typedef struct {
        status_t          status;
        logic [ID_W-1:0]  left_id;
        logic [ID_W-1:0]  right_id;
        logic [ID_W-1:0]  parent_id;
        logic [WT_W-1:0]  weight;
        logic [SYM_W-1:0] symbol;
    } tree_result_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [ACT_W-1:0]  action    = '0;
    logic [SYM_W-1:0]  symbol    = '0;
    logic [LEAF_W-1:0] weight    = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   left_node;
    logic [ID_W-1:0]   right_node;
    logic [ID_W-1:0]   new_node;
    logic [WT_W-1:0]   node_weight;
    logic [SYM_W-1:0]  echo_symbol;

    tree_beat_t   beat_queue[$];
    tree_result_t expected_results[$];
    tree_beat_t   current_beat;
    int           results_issued  = 0;
    int           results_checked = 0;
    int           mismatch_count  = 0;
    int           queued_beats    = 0;
    int           send_gap        = 0;
    int           recv_stall      = 0;
    bit           send_quiet      = 1'b0;
    bit           recv_quiet      = 1'b0;
    bit           tail_reached    = 1'b0;

    // Shadow copy of the node list kept by the predictor.
    logic [WT_W-1:0] live_weights [MAX_LEAVES];
    logic [ID_W-1:0] live_ids     [MAX_LEAVES];
    int unsigned     live_count   = 0;
    logic [ID_W-1:0] id_counter   = '0;
    bit              merge_begun  = 1'b0;

    huffman_tree_merge_builder_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .symbol      (symbol),
        .weight      (weight),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .left_node   (left_node),
        .right_node  (right_node),
        .new_node    (new_node),
        .node_weight (node_weight),
        .echo_symbol (echo_symbol)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Removes the first entry with the strictly lowest weight, keeping order.
    function automatic void pull_lightest(output logic [ID_W-1:0] id,
                                          output logic [WT_W-1:0] wt);
        int best;
        int k;
        best = 0;
        for (k = 1; k < live_count; k++)
        begin
            if (live_weights[k] < live_weights[best])
                best = k;
        end
        id = live_ids[best];
        wt = live_weights[best];
        for (k = best; k + 1 < live_count; k++)
        begin
            live_weights[k] = live_weights[k + 1];
            live_ids[k]     = live_ids[k + 1];
        end
        live_count--;
    endfunction

    function automatic bit predict_tree_step(input tree_beat_t b, output tree_result_t r);
        logic [WT_W-1:0] w_first;
        logic [WT_W-1:0] w_second;
        r.status    = ST_CLEARED;
        r.left_id   = '0;
        r.right_id  = '0;
        r.parent_id = '0;
        r.weight    = '0;
        r.symbol    = '0;
        case (b.action)
            ACT_CLEAR:
            begin
                live_count  = 0;
                id_counter  = '0;
                merge_begun = 1'b0;
            end
            ACT_LOAD:
            begin
                if (merge_begun)
                    r.status = ST_REFUSED;
                else if (live_count >= MAX_LEAVES)
                    r.status = ST_FULL;
                else
                begin
                    live_ids[live_count]     = id_counter;
                    live_weights[live_count] = WT_W'(b.weight);
                    live_count++;
                    r.status   = ST_LOADED;
                    r.left_id  = id_counter;
                    r.weight   = WT_W'(b.weight);
                    r.symbol   = b.symbol;
                    id_counter = id_counter + 1'b1;
                end
            end
            ACT_MERGE:
            begin
                if (live_count == 0)
                    r.status = ST_EMPTY;
                else if (live_count == 1)
                begin
                    merge_begun = 1'b1;
                    r.status    = ST_ROOT;
                    r.left_id   = live_ids[0];
                    r.weight    = live_weights[0];
                end
                else
                begin
                    merge_begun = 1'b1;
                    pull_lightest(r.left_id, w_first);
                    pull_lightest(r.right_id, w_second);
                    r.status    = ST_MERGED;
                    r.weight    = w_first + w_second;
                    r.parent_id = id_counter;
                    live_ids[live_count]     = id_counter;
                    live_weights[live_count] = r.weight;
                    live_count++;
                    id_counter = id_counter + 1'b1;
                end
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic add_beat(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
                            input logic [LEAF_W-1:0] wt, input bit drain = 1'b0);
        tree_beat_t b;
        b.action      = act;
        b.symbol      = sym;
        b.weight      = wt;
        b.drain_first = drain;
        beat_queue = {beat_queue, b};
        if (act != ACT_UNUSED)
            queued_beats++;
    endtask

    // Small weights make ties common; some picks take the extreme values and the rest spread over the full range.
    function automatic logic [LEAF_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0, 1, 2: return LEAF_W'($urandom_range(0, 7));
            3:       return $urandom_range(0, 1) ? '1 : '0;
            default: return LEAF_W'($urandom);
        endcase
    endfunction

    // Sender side: presents queued beats and runs the predictor on each accept.
    always @(posedge clk or negedge rst_n)
    begin
        tree_result_t expected;
        tree_beat_t   next_beat;
        int           owed;
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            action         <= '0;
            symbol         <= '0;
            weight         <= '0;
            results_issued <= 0;
            tail_reached   <= 1'b0;
        end
        else
        begin
            owed = results_issued - results_checked;
            if (in_valid && in_ready)
            begin
                if (predict_tree_step(current_beat, expected))
                begin
                    expected_results = {expected_results, expected};
                    results_issued <= results_issued + 1;
                    owed++;
                end
            end
            tail_reached <= (beat_queue.size() <= TAIL_BEATS);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (beat_queue.size() == 0 || (beat_queue[0].drain_first && owed != 0))
                    in_valid <= 1'b0;
                else if (!send_quiet && beat_queue.size() > TAIL_BEATS
                         && $urandom_range(0, 4) == 0)
                begin
                    send_gap = $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_beat    = beat_queue.pop_front();
                    current_beat = next_beat;
                    in_valid     <= 1'b1;
                    action       <= next_beat.action;
                    symbol       <= next_beat.symbol;
                    weight       <= next_beat.weight;
                    if ($urandom_range(0, 47) == 0)
                        send_quiet = !send_quiet;
                end
            end
        end
    end

    // Receiver side: random back-pressure and in-order checking of result beats.
    always @(posedge clk or negedge rst_n)
    begin
        tree_result_t want;
        if (!rst_n)
        begin
            out_ready       <= 1'b0;
            results_checked <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: status %0d left %0d weight %0h",
                                 status, left_node, node_weight);
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked <= results_checked + 1;
                    if (status !== want.status || left_node !== want.left_id
                        || right_node !== want.right_id || new_node !== want.parent_id
                        || node_weight !== want.weight || echo_symbol !== want.symbol)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%s %0d/%0d/%0d/%0d/%0h/%0h, %s %0d/%0d/%0d/%0d/%0h/%0h",
                                     "result mismatch: expected", want.status, want.left_id,
                                     want.right_id, want.parent_id, want.weight, want.symbol,
                                     "got", status, left_node, right_node, new_node,
                                     node_weight, echo_symbol);
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else if (!tail_reached && !recv_quiet && $urandom_range(0, 5) == 0)
            begin
                recv_stall = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
            if ($urandom_range(0, 63) == 0)
                recv_quiet = !recv_quiet;
        end
    end

    initial
    begin
        int leaves;
        int merges;
        int goal;
        int i;

        // Empty list, dropped action code, single-node root, refused loads.
        add_beat(ACT_MERGE, 8'hFF, '1);
        add_beat(ACT_UNUSED, 8'h00, '0);
        add_beat(ACT_CLEAR, 8'h00, '0);
        add_beat(ACT_LOAD, 8'h00, '0);
        add_beat(ACT_MERGE, 8'h00, '0);
        add_beat(ACT_LOAD, 8'hA5, 24'h5A5A5A);
        add_beat(ACT_MERGE, 8'h00, '0);
        add_beat(ACT_CLEAR, 8'hFF, '1);
        add_beat(ACT_LOAD, 8'hFF, '1);
        add_beat(ACT_LOAD, 8'h55, 24'hAAAAAA);
        add_beat(ACT_LOAD, 8'hAA, 24'h555555);
        // Equal weights: the earliest entry must win each search.
        add_beat(ACT_LOAD, 8'h01, 24'd5);
        add_beat(ACT_LOAD, 8'h02, 24'd5);
        add_beat(ACT_LOAD, 8'h03, 24'd5);
        for (i = 0; i < 4; i++)
            add_beat(ACT_MERGE, 8'h00, '0);
        add_beat(ACT_UNUSED, 8'hFF, '1);
        add_beat(ACT_MERGE, 8'h00, '0);
        add_beat(ACT_MERGE, 8'h00, '0);
        add_beat(ACT_LOAD, 8'h7E, 24'd9);
        add_beat(ACT_CLEAR, 8'h00, '0);
        add_beat(ACT_MERGE, 8'h00, '0);

        // Fill the list to capacity with top weights, overflow it, then merge to the root.
        add_beat(ACT_CLEAR, 8'h00, '0, 1'b1);
        for (i = 0; i < MAX_LEAVES; i++)
            add_beat(ACT_LOAD, SYM_W'(i), '1);
        add_beat(ACT_LOAD, 8'h3C, 24'd1);
        for (i = 0; i < MAX_LEAVES; i++)
            add_beat(ACT_MERGE, 8'h00, '0);
        add_beat(ACT_LOAD, 8'hC3, 24'd1);

        goal = TOTAL_BEATS;
        while (queued_beats < goal)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                add_beat(ACT_CLEAR, SYM_W'($urandom), LEAF_W'($urandom),
                         $urandom_range(0, 19) == 0);
                leaves = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                                     : $urandom_range(1, 16);
                for (i = 0; i < leaves; i++)
                begin
                    add_beat(ACT_LOAD, SYM_W'($urandom), pick_weight());
                    if ($urandom_range(0, 15) == 0)
                        add_beat(ACT_UNUSED, SYM_W'($urandom), LEAF_W'($urandom));
                end
                merges = leaves - 1 + $urandom_range(0, 2);
                for (i = 0; i < merges; i++)
                begin
                    add_beat(ACT_MERGE, SYM_W'($urandom), LEAF_W'($urandom));
                    if ($urandom_range(0, 9) == 0)
                        add_beat(ACT_LOAD, SYM_W'($urandom), pick_weight());
                end
            end
            else
            begin
                leaves = $urandom_range(1, 8);
                for (i = 0; i < leaves; i++)
                    add_beat(ACT_UNUSED - ACT_W'($urandom_range(0, 3)),
                             SYM_W'($urandom), pick_weight());
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (beat_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (results_issued != results_checked)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("huffman_tree_merge_builder_unit_tb: PASS");
        else
            $display("huffman_tree_merge_builder_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("huffman_tree_merge_builder_unit_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/htmb_pkg.sv
rtl/core/htmb_ctrl.sv
rtl/core/htmb_dp.sv
rtl/core/huffman_tree_merge_builder_unit.sv
bench/huffman_tree_merge_builder_unit_tb.sv
